[design/deq_pkg.sv]
// Shared types and codes for the double-ended queue.
// Holds the request and response item layouts and the request and status codes.
// No dependencies.
`default_nettype none

package deq_pkg;

    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Request codes; the remaining codes of the field are no-ops.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_OVERWRITE  = 3'd4;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] popped;
        t_status            status;
        logic [OCC_W-1:0]   occupancy;
        logic [VALUE_W-1:0] front_value;
        logic [VALUE_W-1:0] back_value;
    } t_rsp;

    // Decoded outcome of one request, from the pointer logic to the datapath.
    typedef struct packed {
        t_status status;
        logic    take_front;
        logic    take_back;
        logic    wr_en;
    } t_step;

endpackage

`default_nettype wire

[design/double_ended_queue.sv]
// Fixed-capacity double-ended queue on a circular buffer of DEPTH slots of WIDTH bits.
// One request per item (push front, push back, pop front, pop back, overwrite at
// a position), one response per request. The block takes one request every clock
// cycle while o_req_stall is low. An accepted request goes through the read stage,
// where the slot memory's registered reads give the new front and back, and then
// the output register. The rate is set by the slot memory, which takes one write
// and two reads per cycle. A popped value comes from the front and back values kept
// after the previous request, so no third read is needed. o_req_stall rises only
// while a response waits in the output register and the read stage behind it is full.
// Depends on deq_pkg, deq_ptr and deq_ram.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_stall,
    output t_rsp      o_rsp
);

    localparam int AW = $clog2(DEPTH);

    t_step            step;
    logic [AW-1:0]    wr_addr;
    logic [WIDTH-1:0] wr_data;
    logic [AW-1:0]    front_addr;
    logic [AW-1:0]    back_addr;
    logic [AW:0]      held_next;
    logic [WIDTH-1:0] rd_front;
    logic [WIDTH-1:0] rd_back;

    logic accept;
    logic wr_go;
    logic out_adv;
    logic b_adv;

    // Read stage: memory data plus what was decided at acceptance.
    logic             r_b_vld;
    t_status          r_b_status;
    logic [AW:0]      r_b_held;
    logic [31:0]      r_b_popped;
    logic             r_b_hit_f;
    logic             r_b_hit_b;
    logic [WIDTH-1:0] r_b_wdata;

    logic [WIDTH-1:0] r_cur_front;
    logic [WIDTH-1:0] r_cur_back;
    logic             r_o_vld;
    t_rsp             r_o_rsp;

    logic [WIDTH-1:0] b_front;
    logic [WIDTH-1:0] b_back;
    logic [WIDTH-1:0] cur_front;
    logic [WIDTH-1:0] cur_back;
    logic [31:0]      n_popped;
    logic [AW+5:0]    occ_w;
    t_rsp             n_rsp;

    function automatic logic [31:0] to_out(input logic [WIDTH-1:0] d);
        logic [WIDTH+31:0] t;
        t = (WIDTH+32)'(d);
        return t[31:0];
    endfunction

    assign out_adv     = !r_o_vld || !i_rsp_stall;
    assign b_adv       = r_b_vld && out_adv;
    assign o_req_stall = r_b_vld && !out_adv;
    assign accept      = i_req_valid && !o_req_stall;
    assign wr_go       = accept && step.wr_en;

    deq_ptr #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_ptr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_accept     (accept),
        .o_step       (step),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_front_addr (front_addr),
        .o_back_addr  (back_addr),
        .o_held_next  (held_next)
    );

    deq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk       (i_clk),
        .i_wr_en     (wr_go),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (accept),
        .i_rd_addr_a (front_addr),
        .i_rd_addr_b (back_addr),
        .o_rd_data_a (rd_front),
        .o_rd_data_b (rd_back)
    );

    // The memory returns old data on a same-cycle write, so forward the write.
    assign b_front = r_b_hit_f ? r_b_wdata : rd_front;
    assign b_back  = r_b_hit_b ? r_b_wdata : rd_back;

    // Front and back after the most recently accepted request.
    assign cur_front = r_b_vld ? b_front : r_cur_front;
    assign cur_back  = r_b_vld ? b_back : r_cur_back;

    always_comb begin
        n_popped = '0;
        if (step.take_front) begin
            n_popped = to_out(cur_front);
        end else if (step.take_back) begin
            n_popped = to_out(cur_back);
        end
    end

    assign occ_w = (AW+6)'(r_b_held);

    always_comb begin
        n_rsp.popped    = r_b_popped;
        n_rsp.status    = r_b_status;
        n_rsp.occupancy = occ_w[OCC_W-1:0];
        if (r_b_held == '0) begin
            n_rsp.front_value = '0;
            n_rsp.back_value  = '0;
        end else begin
            n_rsp.front_value = to_out(b_front);
            n_rsp.back_value  = to_out(b_back);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_b_vld <= 1'b1;
            end else if (b_adv) begin
                r_b_vld <= 1'b0;
            end
            if (b_adv) begin
                r_o_vld <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_status <= step.status;
            r_b_held   <= held_next;
            r_b_popped <= n_popped;
            r_b_hit_f  <= wr_go && (wr_addr == front_addr);
            r_b_hit_b  <= wr_go && (wr_addr == back_addr);
            r_b_wdata  <= wr_data;
        end
        if (r_b_vld) begin
            r_cur_front <= b_front;
            r_cur_back  <= b_back;
        end
        if (b_adv) begin
            r_o_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_o_vld;
    assign o_rsp       = r_o_rsp;

    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld && !out_adv |=> r_b_vld && $stable(r_b_held) && $stable(r_b_status))
        else $error("read stage changed while its response was blocked");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld && (r_b_status == ST_FULL) |-> r_b_held == (AW+1)'(DEPTH))
        else $error("full status with room left in the queue");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld && (r_b_status == ST_EMPTY) |-> r_b_held == '0)
        else $error("empty status on a non-empty queue");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_b_vld)
        else $error("accepted item did not reach the read stage");

endmodule

`default_nettype wire

[design/deq_ram.sv]
// Generic RAM with one write port and two registered read ports.
// A read at the address being written returns the old contents.
// No dependencies.
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr_a,
    input  wire logic [AW-1:0]    i_rd_addr_b,
    output logic      [WIDTH-1:0] o_rd_data_a,
    output logic      [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

[design/deq_ptr.sv]
// Head pointer and element count of the queue, with request decode.
// Produces the slot write and the slot addresses of the new front and back.
// Depends on deq_pkg.
`default_nettype none

module deq_ptr
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_req             i_req,
    input  wire logic             i_accept,
    output t_step                 o_step,
    output logic      [AW-1:0]    o_wr_addr,
    output logic      [WIDTH-1:0] o_wr_data,
    output logic      [AW-1:0]    o_front_addr,
    output logic      [AW-1:0]    o_back_addr,
    output logic      [AW:0]      o_held_next
);

    logic [AW-1:0] r_head;
    logic [AW:0]   r_held;
    logic [AW-1:0] n_head;
    logic [AW:0]   n_held;

    logic                  full;
    logic                  empty;
    logic [AW+4:0]         pos_w;
    logic [AW+4:0]         held_w;
    logic [WIDTH+31:0]     value_w;
    t_step                 step;
    logic [AW-1:0]         wr_addr;

    // Slot of the element at offset off from base; both stay below DEPTH.
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
                                              input logic [AW:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign full    = (r_held == (AW+1)'(DEPTH));
    assign empty   = (r_held == '0);
    assign pos_w   = (AW+5)'(i_req.position);
    assign held_w  = (AW+5)'(r_held);
    assign value_w = (WIDTH+32)'(i_req.value);

    always_comb begin
        n_head          = r_head;
        n_held          = r_held;
        wr_addr         = r_head;
        step.status     = ST_OK;
        step.take_front = 1'b0;
        step.take_back  = 1'b0;
        step.wr_en      = 1'b0;
        unique case (i_req.req_type)
            REQ_PUSH_FRONT: begin
                if (full) begin
                    step.status = ST_FULL;
                end else begin
                    n_head     = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
                    wr_addr    = n_head;
                    step.wr_en = 1'b1;
                    n_held     = r_held + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (full) begin
                    step.status = ST_FULL;
                end else begin
                    wr_addr    = slot_at(r_head, r_held);
                    step.wr_en = 1'b1;
                    n_held     = r_held + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    step.status = ST_EMPTY;
                end else begin
                    step.take_front = 1'b1;
                    n_head          = slot_at(r_head, (AW+1)'(1));
                    n_held          = r_held - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    step.status = ST_EMPTY;
                end else begin
                    step.take_back = 1'b1;
                    n_held         = r_held - 1'b1;
                end
            end
            REQ_OVERWRITE: begin
                if (pos_w >= held_w) begin
                    step.status = ST_RANGE;
                end else begin
                    wr_addr    = slot_at(r_head, pos_w[AW:0]);
                    step.wr_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_held <= '0;
        end else if (i_accept) begin
            r_head <= n_head;
            r_held <= n_held;
        end
    end

    assign o_step       = step;
    assign o_wr_addr    = wr_addr;
    assign o_wr_data    = value_w[WIDTH-1:0];
    assign o_front_addr = n_head;
    // Meaningless when the queue ends up empty; the response zeroes it then.
    assign o_back_addr  = slot_at(n_head, n_held - 1'b1);
    assign o_held_next  = n_held;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= (AW+1)'(DEPTH))
        else $error("element count exceeds capacity");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (step.take_front || step.take_back)
        |=> r_held == $past(r_held) - 1'b1)
        else $error("successful pop did not decrement the count");

endmodule

`default_nettype wire

[tb/double_ended_queue_tb.sv]
// Self-checking testbench for double_ended_queue: a directed table, then random requests.
// Typed directed rows are checked against their table values, all others against a behavioral deque model.
// Depends on deq_pkg and double_ended_queue.
`default_nettype none

module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int DEPTH = 16;
    localparam int PTR_W = 4;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_FROM = 340;
    localparam int MAX_PRINTS = 40;

    // Request codes that the block treats as no-ops.
    localparam logic [REQ_W-1:0] REQ_NOP_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_NOP_HI = 3'd7;

    typedef struct {
        t_req req;
        int   reps;
        bit   typed;
        t_rsp want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_stall;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_stall;
    t_rsp o_rsp;

    // Deque model state.
    logic [VALUE_W-1:0] model_slots [DEPTH];
    logic [PTR_W-1:0]   model_head;
    logic [OCC_W-1:0]   model_count;

    t_rsp     expected_rsps [$];
    t_dir_row dir_rows [$];
    int       mismatches;
    int       rsp_seen;
    bit       idling_on;

    double_ended_queue #(
        .DEPTH(DEPTH),
        .WIDTH(VALUE_W)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .o_rsp      (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [PTR_W-1:0] slot_of(input logic [OCC_W-1:0] offset);
        return model_head + offset[PTR_W-1:0];
    endfunction

    function automatic t_rsp make_rsp(input logic [VALUE_W-1:0] popped,
                                      input t_status status,
                                      input int occupancy,
                                      input logic [VALUE_W-1:0] front_value,
                                      input logic [VALUE_W-1:0] back_value);
        t_rsp rsp;
        rsp.popped      = popped;
        rsp.status      = status;
        rsp.occupancy   = OCC_W'(occupancy);
        rsp.front_value = front_value;
        rsp.back_value  = back_value;
        return rsp;
    endfunction

    // Applies one request to the model and returns the response it should produce.
    function automatic t_rsp deque_apply(input t_req r);
        t_rsp rsp;
        rsp = '0;
        rsp.status = ST_OK;
        case (r.req_type)
            REQ_PUSH_FRONT: begin
                if (model_count == DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    model_head = model_head - 1'b1;
                    model_slots[model_head] = r.value;
                    model_count = model_count + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                if (model_count == DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    model_slots[slot_of(model_count)] = r.value;
                    model_count = model_count + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (model_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.popped = model_slots[model_head];
                    model_head = model_head + 1'b1;
                    model_count = model_count - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                if (model_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.popped = model_slots[slot_of(model_count - 1'b1)];
                    model_count = model_count - 1'b1;
                end
            end
            REQ_OVERWRITE: begin
                if ({1'b0, r.position} >= model_count) begin
                    rsp.status = ST_RANGE;
                end else begin
                    model_slots[slot_of({1'b0, r.position})] = r.value;
                end
            end
            default: begin
            end
        endcase
        rsp.occupancy = model_count;
        if (model_count != 0) begin
            rsp.front_value = model_slots[model_head];
            rsp.back_value  = model_slots[slot_of(model_count - 1'b1)];
        end
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at response %0d, %s: got %h, expected %h",
                     rsp_seen, what, got, want);
        mismatches++;
    endtask

    task automatic add_row(input logic [REQ_W-1:0] code, input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos, input int reps, input int typed,
                           input t_rsp want);
        t_dir_row row;
        row.req.req_type = code;
        row.req.value    = value;
        row.req.position = pos;
        row.reps  = reps;
        row.typed = (typed != 0);
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Drives one item, waits until it is taken, and records what it should produce.
    task automatic send_req(input t_req r, input bit typed, input t_rsp want);
        t_rsp predicted;
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        predicted = deque_apply(r);
        expected_rsps.push_back(typed ? want : predicted);
    endtask

    initial begin : rsp_stall_gen
        int n;
        i_rsp_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                i_rsp_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("response with nothing expected", o_rsp.popped, '0);
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.popped !== want.popped)
                    report_mismatch("popped", o_rsp.popped, want.popped);
                if (o_rsp.status !== want.status)
                    report_mismatch("status", VALUE_W'(o_rsp.status),
                                    VALUE_W'(want.status));
                if (o_rsp.occupancy !== want.occupancy)
                    report_mismatch("occupancy", VALUE_W'(o_rsp.occupancy),
                                    VALUE_W'(want.occupancy));
                if (o_rsp.front_value !== want.front_value)
                    report_mismatch("front_value", o_rsp.front_value, want.front_value);
                if (o_rsp.back_value !== want.back_value)
                    report_mismatch("back_value", o_rsp.back_value, want.back_value);
            end
            rsp_seen++;
        end
    end

    initial begin : stimulus
        t_req r;
        int done_items;
        int pick;
        bit fill_phase;
        bit drained;
        mismatches  = 0;
        rsp_seen    = 0;
        idling_on   = 1'b1;
        drained     = 1'b0;
        done_items  = 0;
        model_head  = '0;
        model_count = '0;
        foreach (model_slots[k]) model_slots[k] = '0;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;

        // Directed part, starting from the empty queue after reset.
        add_row(REQ_POP_FRONT, 32'h0, 4'd0, 1, 1, make_rsp(0, ST_EMPTY, 0, 0, 0));
        add_row(REQ_POP_BACK, 32'hFFFFFFFF, 4'd15, 1, 1, make_rsp(0, ST_EMPTY, 0, 0, 0));
        add_row(REQ_OVERWRITE, 32'h1, 4'd0, 1, 1, make_rsp(0, ST_RANGE, 0, 0, 0));
        add_row(REQ_NOP_HI, 32'hFFFFFFFF, 4'd15, 1, 1, make_rsp(0, ST_OK, 0, 0, 0));
        add_row(REQ_PUSH_FRONT, 32'hFFFFFFFF, 4'd0, 1, 1,
                make_rsp(0, ST_OK, 1, 32'hFFFFFFFF, 32'hFFFFFFFF));
        add_row(REQ_PUSH_BACK, 32'h0, 4'd0, 1, 1, make_rsp(0, ST_OK, 2, 32'hFFFFFFFF, 0));
        add_row(REQ_OVERWRITE, 32'h1, 4'd2, 1, 1, make_rsp(0, ST_RANGE, 2, 32'hFFFFFFFF, 0));
        add_row(REQ_OVERWRITE, 32'h12345678, 4'd1, 1, 1,
                make_rsp(0, ST_OK, 2, 32'hFFFFFFFF, 32'h12345678));
        add_row(REQ_POP_FRONT, 32'h0, 4'd0, 1, 1,
                make_rsp(32'hFFFFFFFF, ST_OK, 1, 32'h12345678, 32'h12345678));
        add_row(REQ_PUSH_FRONT, 32'h0, 4'd0, 1, 1, make_rsp(0, ST_OK, 2, 0, 32'h12345678));
        add_row(REQ_NOP_LO, 32'h5A5A5A5A, 4'd7, 1, 0, '0);
        // Fill to capacity from the front so the elements wrap past the buffer's end, then push when full.
        add_row(REQ_PUSH_FRONT, 32'h00001000, 4'd0, 14, 0, '0);
        add_row(REQ_PUSH_BACK, 32'hDEADBEEF, 4'd0, 1, 0, '0);
        add_row(REQ_PUSH_FRONT, 32'hCAFEF00D, 4'd0, 1, 0, '0);
        add_row(REQ_OVERWRITE, 32'hFFFF0000, 4'd15, 1, 0, '0);
        add_row(REQ_POP_BACK, 32'h0, 4'd0, 3, 0, '0);
        add_row(REQ_POP_FRONT, 32'h0, 4'd0, 3, 0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            for (int k = 0; k < dir_rows[i].reps; k++) begin
                r = dir_rows[i].req;
                r.value = r.value + k;
                send_req(r, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random part: alternating fill-heavy and drain-heavy stretches so that
        // the queue keeps reaching both full and empty.
        while (done_items < RANDOM_ITEMS) begin
            idling_on = (done_items < QUIET_FROM) && ((done_items / 50) % 3 != 2);
            if (done_items == 200 && !drained) begin
                drained = 1'b1;
                i_req_valid <= 1'b0;
                while (expected_rsps.size() != 0) @(posedge i_clk);
            end
            fill_phase = ((done_items / 40) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                r.req_type = REQ_W'($urandom_range(REQ_NOP_LO, REQ_NOP_HI));
            else if (pick < 15)
                r.req_type = REQ_OVERWRITE;
            else if (pick < (fill_phase ? 75 : 40))
                r.req_type = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            else
                r.req_type = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
            case ($urandom_range(0, 9))
                0:       r.value = '0;
                1:       r.value = '1;
                default: r.value = $urandom;
            endcase
            if (model_count != 0 && $urandom_range(0, 4) != 0)
                r.position = POS_W'($urandom_range(0, model_count - 1));
            else
                r.position = POS_W'($urandom_range(0, DEPTH - 1));
            send_req(r, 1'b0, '0);
            if (r.req_type < REQ_NOP_LO)
                done_items++;
        end

        idling_on = 1'b0;
        i_req_valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
